### rtl/core/pba_pkg.sv
`default_nettype none

package pba_pkg;

   // Bitmap geometry. One bit per page, 32 pages per word.
   localparam int BITMAP_WORDS = 1024;
   localparam int KERNEL_WORDS = 16;
   localparam int IDX_W        = $clog2(BITMAP_WORDS);
   localparam int END_W        = $clog2(BITMAP_WORDS + 1);
   localparam int CMP_W        = 17;
   localparam int PAGE_W       = 15;
   localparam int WORD_W       = 10;
   localparam int FREE_W       = 16;

   localparam logic [31:0]       FULL_WORD   = 32'hffff_ffff;
   localparam logic [FREE_W-1:0] FREE_RESET  = 16'd32256;
   localparam logic [FREE_W-1:0] FREE_MAX    = 16'hffff;
   localparam logic [9:0]        START_RESET = 10'd16;
   localparam logic [10:0]       WORDS_RESET = 11'd1024;

   // Input mode codes.
   localparam logic [1:0] MODE_FIND    = 2'd0;
   localparam logic [1:0] MODE_RESERVE = 2'd1;
   localparam logic [1:0] MODE_RELEASE = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_SEARCH_START = 1'b0;
   localparam logic CSR_WORDS_IN_USE = 1'b1;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_NOP,
      OP_FIND,
      OP_RESERVE,
      OP_RELEASE
   } op_kind_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [PAGE_W-1:0] block_number;
   } req_type;

   typedef struct packed {
      logic [PAGE_W-1:0] found_block;
      logic              found;
      logic              changed;
      logic [FREE_W-1:0] free_pages;
   } rsp_type;

   // A classified operation as it travels from front to back.
   typedef struct packed {
      op_kind_type      kind;
      logic [WORD_W-1:0] word;
      logic [4:0]        bit_sel;
      logic              in_range;
      logic              scan_none;
      logic [IDX_W-1:0]  scan_start;
      logic [END_W-1:0]  scan_end;
   } op_type;

endpackage

`default_nettype wire

### rtl/core/pba_front.sv
`default_nettype none

module pba_front
   import pba_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   csr_we,
   input  wire logic   csr_index,
   input  wire logic [10:0] csr_wdata,
   input  wire logic   req_push,
   input  wire req_type req_data,
   output logic        req_full,
   input  wire logic   q_full,
   input  wire logic   clearing,
   output logic        q_push,
   output op_type      q_data
);

   logic [9:0]       search_start_ff, search_start_in;
   logic [10:0]      words_in_use_ff, words_in_use_in;
   logic [CMP_W-1:0] end_cmp;
   logic [CMP_W-1:0] word_cmp;

   // Configuration registers.
   always_comb begin
      search_start_in = search_start_ff;
      words_in_use_in = words_in_use_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SEARCH_START: search_start_in = csr_wdata[9:0];
            CSR_WORDS_IN_USE: words_in_use_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         search_start_ff <= START_RESET;
         words_in_use_ff <= WORDS_RESET;
      end else begin
         search_start_ff <= search_start_in;
         words_in_use_ff <= words_in_use_in;
      end
   end

   // Items are refused while the bitmap is being initialized.
   assign req_full = q_full | clearing;
   assign q_push   = req_push & ~req_full;

   // The scan ends at the lesser of the words in use and the bitmap size.
   always_comb begin
      if (CMP_W'(words_in_use_ff) < CMP_W'(BITMAP_WORDS)) begin
         end_cmp = CMP_W'(words_in_use_ff);
      end else begin
         end_cmp = CMP_W'(BITMAP_WORDS);
      end
   end

   assign word_cmp = CMP_W'(req_data.block_number[PAGE_W-1:5]);

   // Classify the item into an operation for the back end.
   always_comb begin
      unique case (req_data.mode)
         MODE_FIND:    q_data.kind = OP_FIND;
         MODE_RESERVE: q_data.kind = OP_RESERVE;
         MODE_RELEASE: q_data.kind = OP_RELEASE;
         default:      q_data.kind = OP_NOP;
      endcase
      q_data.word       = req_data.block_number[PAGE_W-1:5];
      q_data.bit_sel    = req_data.block_number[4:0];
      q_data.in_range   = word_cmp < CMP_W'(BITMAP_WORDS);
      q_data.scan_none  = CMP_W'(search_start_ff) >= end_cmp;
      q_data.scan_start = IDX_W'(search_start_ff);
      q_data.scan_end   = END_W'(end_cmp);
   end

endmodule

`default_nettype wire

### rtl/core/pba_queue.sv
`default_nettype none

module pba_queue
   import pba_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  wire op_type push_data,
   output logic        full,
   input  wire logic   pop,
   output op_type      pop_data,
   output logic        empty
);

   op_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### rtl/core/pba_back.sv
`default_nettype none

module pba_back
   import pba_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   q_empty,
   input  wire op_type q_head,
   output logic        q_pop,
   output logic        clearing,
   output rsp_type     rsp_data,
   output logic        rsp_empty,
   input  wire logic   rsp_pop
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_MREAD,
      S_MODIFY,
      S_FSCAN
   } state_type;

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [IDX_W-1:0]  clr_ff, clr_in;
   logic [IDX_W-1:0]  issue_ff, issue_in;
   logic [IDX_W-1:0]  chk_ff, chk_in;
   logic              chk_valid_ff, chk_valid_in;
   logic [FREE_W-1:0] free_ff, free_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [31:0]       bitmap_mem [BITMAP_WORDS];
   logic [31:0]       rd_data_ff;
   logic [IDX_W-1:0]  rd_addr;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [31:0]       mem_wdata;
   logic [31:0]       bit_mask;
   logic              bit_set;
   logic [END_W-1:0]  chk_next;

   // Position of the lowest clear bit of a word that is not full.
   function automatic logic [4:0] lowest_zero(input logic [31:0] word);
      logic [4:0] pos;
      pos = '0;
      for (int b = 31; b >= 0; b--) begin
         if (!word[b]) begin
            pos = 5'(b);
         end
      end
      return pos;
   endfunction

   assign clearing  = state_ff == S_CLEAR;
   assign rsp_data  = rsp_ff;
   assign rsp_empty = ~rsp_valid_ff;
   assign bit_mask  = 32'd1 << op_ff.bit_sel;
   assign bit_set   = (rd_data_ff & bit_mask) != '0;
   assign chk_next  = END_W'(chk_ff) + END_W'(1);

   // Sequencer for initialization, read-modify-write and the find scan.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      clr_in       = clr_ff;
      issue_in     = issue_ff;
      chk_in       = chk_ff;
      chk_valid_in = chk_valid_ff;
      free_in      = free_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_pop;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = clr_ff;
      mem_wdata    = '0;
      rd_addr      = issue_ff;

      unique case (state_ff)
         S_CLEAR: begin
            // Kernel words start reserved, the rest start free.
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = (CMP_W'(clr_ff) < CMP_W'(KERNEL_WORDS)) ? FULL_WORD : '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == IDX_W'(BITMAP_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            // Take the next operation once the result register is free.
            if (!q_empty && !rsp_valid_ff) begin
               q_pop              = 1'b1;
               op_in              = q_head;
               rsp_in.found_block = '0;
               rsp_in.found       = 1'b0;
               rsp_in.changed     = 1'b0;
               rsp_in.free_pages  = free_ff;
               unique case (q_head.kind)
                  OP_FIND: begin
                     if (q_head.scan_none) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        issue_in     = q_head.scan_start;
                        chk_valid_in = 1'b0;
                        state_in     = S_FSCAN;
                     end
                  end
                  OP_RESERVE, OP_RELEASE: begin
                     if (q_head.in_range) begin
                        state_in = S_MREAD;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         S_MREAD: begin
            rd_addr  = IDX_W'(op_ff.word);
            state_in = S_MODIFY;
         end

         S_MODIFY: begin
            // Flip the page bit only if it is in the opposite state.
            mem_waddr = IDX_W'(op_ff.word);
            if (op_ff.kind == OP_RESERVE && !bit_set) begin
               mem_we         = 1'b1;
               mem_wdata      = rd_data_ff | bit_mask;
               rsp_in.changed = 1'b1;
               if (free_ff != '0) begin
                  free_in = free_ff - 1'b1;
               end
            end else if (op_ff.kind == OP_RELEASE && bit_set) begin
               mem_we         = 1'b1;
               mem_wdata      = rd_data_ff & ~bit_mask;
               rsp_in.changed = 1'b1;
               if (free_ff != FREE_MAX) begin
                  free_in = free_ff + 1'b1;
               end
            end
            rsp_in.free_pages = free_in;
            rsp_valid_in      = 1'b1;
            state_in          = S_IDLE;
         end

         S_FSCAN: begin
            // One word is read per cycle; the word read last cycle is checked.
            rd_addr = issue_ff;
            if (chk_valid_ff && rd_data_ff != FULL_WORD) begin
               rsp_in.found_block = PAGE_W'({chk_ff, lowest_zero(rd_data_ff)});
               rsp_in.found       = 1'b1;
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end else if (chk_valid_ff && chk_next == op_ff.scan_end) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               chk_in       = issue_ff;
               chk_valid_in = 1'b1;
               issue_in     = issue_ff + 1'b1;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         chk_valid_ff <= 1'b0;
         free_ff      <= FREE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         chk_valid_ff <= chk_valid_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff    <= op_in;
      issue_ff <= issue_in;
      chk_ff   <= chk_in;
      rsp_ff   <= rsp_in;
   end

   // Bitmap memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bitmap_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= bitmap_mem[rd_addr];
   end

endmodule

`default_nettype wire

### rtl/core/page_bitmap_allocator.sv
// Channel   Direction  Handshake             Payload
// req       in         req_push / req_full   req_data (mode, block_number)
// rsp       out        rsp_pop / rsp_empty   rsp_data (found_block, found, changed, free_pages)
// csr       in         csr_we                csr_index, csr_wdata
//
// After reset the bitmap is initialized one word per cycle, with req_full high.
// Reserve and release go from the queue head through a read state, then a modify and write state.
// Find scans the words of its window in turn, paced by the single bitmap read port.
// A find over an empty scan window and the unused mode are answered from the idle state, without a bitmap access.
// Up to two items wait in the queue while the result register holds an unread result.

`default_nettype none

module page_bitmap_allocator
   import pba_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [10:0] csr_wdata,
   input  wire logic        req_push,
   input  wire req_type     req_data,
   output logic             req_full,
   input  wire logic        rsp_pop,
   output rsp_type          rsp_data,
   output logic             rsp_empty
);

   logic   q_push, q_full, q_pop, q_empty, clearing;
   op_type q_in, q_head;

   // Front end: configuration and item classification.
   pba_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .q_full    (q_full),
      .clearing  (clearing),
      .q_push    (q_push),
      .q_data    (q_in)
   );

   // Queue of classified operations.
   pba_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_head),
      .empty     (q_empty)
   );

   // Back end: bitmap memory, free counter and result register.
   pba_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .clearing  (clearing),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

endmodule

`default_nettype wire

### verif/page_alloc_checker.sv
`timescale 1ns / 100ps

module page_alloc_checker
   import pba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [10:0] csr_wdata,
   input  logic        req_push,
   input  logic        req_full,
   input  req_type     req_data,
   input  logic        rsp_pop,
   input  logic        rsp_empty,
   input  rsp_type     rsp_data,
   output int          mismatches,
   output int          awaiting,
   output int          checked,
   output int          finds_hit,
   output int          finds_missed
);

   // Shadow copy of the page bitmap, the free counter and the scan registers.
   logic [31:0]       shadow_bitmap [BITMAP_WORDS];
   logic [FREE_W-1:0] shadow_free;
   logic [9:0]        scan_first;
   logic [10:0]       scan_limit;

   // Results still owed by the allocator, oldest first.
   rsp_type           owed_results [$];

   // Applies one request to the shadow state and returns the result it must produce.
   function automatic rsp_type allocate_step(input req_type item);
      rsp_type          res;
      logic [10:0]      last;
      logic [10:0]      w;
      logic [IDX_W-1:0] page_word;
      logic [4:0]       bit_pos;
      logic             was_set;
      res = '0;
      if (item.mode == MODE_FIND) begin
         // Scan from the start word to the lesser of the word count and the bitmap size.
         last = (scan_limit > 11'(BITMAP_WORDS)) ? 11'(BITMAP_WORDS) : scan_limit;
         for (w = {1'b0, scan_first}; w < last && !res.found; w++) begin
            if (shadow_bitmap[w[IDX_W-1:0]] != FULL_WORD) begin
               bit_pos = '0;
               while (shadow_bitmap[w[IDX_W-1:0]][bit_pos]) bit_pos++;
               res.found_block = {w[IDX_W-1:0], bit_pos};
               res.found = 1'b1;
            end
         end
      end else if (item.mode == MODE_RESERVE || item.mode == MODE_RELEASE) begin
         // A 15-bit page number always falls inside the bitmap.
         page_word = item.block_number[PAGE_W-1:5];
         bit_pos = item.block_number[4:0];
         was_set = shadow_bitmap[page_word][bit_pos];
         if (item.mode == MODE_RESERVE && !was_set) begin
            shadow_bitmap[page_word][bit_pos] = 1'b1;
            if (shadow_free != '0) shadow_free = shadow_free - 1'b1;
            res.changed = 1'b1;
         end else if (item.mode == MODE_RELEASE && was_set) begin
            shadow_bitmap[page_word][bit_pos] = 1'b0;
            if (shadow_free != FREE_MAX) shadow_free = shadow_free + 1'b1;
            res.changed = 1'b1;
         end
      end
      res.free_pages = shadow_free;
      return res;
   endfunction

   // Field by field comparison of one result against the oldest one owed.
   function automatic void compare_result(input rsp_type want, input rsp_type got);
      if (got.found_block !== want.found_block) begin
         $error("found_block: expected %0d, got %0d", want.found_block, got.found_block);
         mismatches++;
      end
      if (got.found !== want.found) begin
         $error("found: expected %0d, got %0d", want.found, got.found);
         mismatches++;
      end
      if (got.changed !== want.changed) begin
         $error("changed: expected %0d, got %0d", want.changed, got.changed);
         mismatches++;
      end
      if (got.free_pages !== want.free_pages) begin
         $error("free_pages: expected %0d, got %0d", want.free_pages, got.free_pages);
         mismatches++;
      end
   endfunction

   // Everything is sampled at the rising edge, before the allocator's own updates land.
   always @(posedge clock) begin : watch
      int      w;
      rsp_type want;
      rsp_type got;
      if (reset) begin
         for (w = 0; w < BITMAP_WORDS; w++) begin
            shadow_bitmap[w[IDX_W-1:0]] = (w < KERNEL_WORDS) ? FULL_WORD : 32'h0;
         end
         shadow_free = FREE_RESET;
         scan_first = START_RESET;
         scan_limit = WORDS_RESET;
         owed_results.delete();
         mismatches = 0;
         checked = 0;
         finds_hit = 0;
         finds_missed = 0;
      end else begin
         // A result leaves before a request arriving in the same cycle is counted.
         if (rsp_pop && !rsp_empty) begin
            got = rsp_data;
            if (owed_results.size() == 0) begin
               $error("unexpected result: found_block %0d, found %0d, changed %0d, free %0d",
                      got.found_block, got.found, got.changed, got.free_pages);
               mismatches++;
            end else begin
               want = owed_results.pop_front();
               compare_result(want, got);
               checked++;
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_SEARCH_START) scan_first = csr_wdata[9:0];
            else if (csr_index == CSR_WORDS_IN_USE) scan_limit = csr_wdata;
         end
         if (req_push && !req_full) begin
            want = allocate_step(req_data);
            if (req_data.mode == MODE_FIND) begin
               if (want.found) finds_hit++;
               else finds_missed++;
            end
            owed_results.push_back(want);
         end
      end
      awaiting = owed_results.size();
   end

endmodule

### verif/tb_page_bitmap_allocator.sv
`timescale 1ns / 100ps

module tb_page_bitmap_allocator;
   import pba_pkg::*;

   // The unused mode code; the allocator must answer it without touching state.
   localparam logic [1:0] MODE_IDLE = 2'd3;
   localparam int RANDOM_PHASES = 16;
   localparam int PHASE_ITEMS   = 100;
   localparam int CYCLE_LIMIT   = 1000000;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic        csr_index;
   logic [10:0] csr_wdata;
   logic        req_push;
   req_type     req_data;
   logic        req_full;
   logic        rsp_pop;
   rsp_type     rsp_data;
   logic        rsp_empty;

   int mismatches;
   int awaiting;
   int checked;
   int finds_hit;
   int finds_missed;
   int offered = 0;
   int settings = 1;
   int cycle_count = 0;
   int rsp_hold = 0;
   logic tx_burst = 1'b0;
   logic rsp_burst = 1'b0;

   always #5 clock = ~clock;

   page_bitmap_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty)
   );

   page_alloc_checker scoreboard (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_data     (req_data),
      .rsp_pop      (rsp_pop),
      .rsp_empty    (rsp_empty),
      .rsp_data     (rsp_data),
      .mismatches   (mismatches),
      .awaiting     (awaiting),
      .checked      (checked),
      .finds_hit    (finds_hit),
      .finds_missed (finds_missed)
   );

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Offers one item after a random gap and holds it until the allocator takes it.
   task automatic offer_request(input logic [1:0] op_mode, input logic [PAGE_W-1:0] page);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, 10);
      repeat (gap) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= req_type'{mode: op_mode, block_number: page};
      do @(posedge clock); while (req_full);
      @(negedge clock);
      offered++;
   endtask

   // Stops offering and waits until every owed result has been taken.
   task automatic settle();
      req_push <= 1'b0;
      while (awaiting != 0) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic set_register(input logic index, input logic [10:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // New scan window, written only once the allocator has gone idle.
   task automatic configure(input logic [9:0] first_word, input logic [10:0] word_count);
      settle();
      set_register(CSR_SEARCH_START, {1'b0, first_word});
      set_register(CSR_WORDS_IN_USE, word_count);
      settings++;
   endtask

   // Result side: random gaps per item, runs of back-to-back pops, and one long hold.
   initial begin : result_side
      int gap;
      int served;
      served = 0;
      rsp_pop = 1'b0;
      @(negedge clock);
      forever begin
         if (rsp_hold != 0) begin
            gap = rsp_hold;
            rsp_hold = 0;
         end else if (rsp_burst) begin
            gap = 0;
         end else begin
            gap = $urandom_range(0, 10);
         end
         repeat (gap) begin
            rsp_pop <= 1'b0;
            @(negedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         @(negedge clock);
         served++;
         if (served % 40 == 0) rsp_burst = ($urandom_range(0, 3) == 0);
      end
   end

   // Stimulus: directed corner cases, then random phases over moving scan windows.
   initial begin : request_side
      int phase;
      int k;
      int pick;
      int first;
      int span;
      int limit;
      int roll;
      int cursor;
      logic fill;
      logic [PAGE_W-1:0] page;

      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_SEARCH_START;
      csr_wdata = '0;
      req_push = 1'b0;
      req_data = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // The bitmap clears itself after reset with the input side reporting full.
      @(negedge clock);
      while (req_full) @(negedge clock);

      // Reset window: first free page, repeated reserve and release, kernel and top pages.
      offer_request(MODE_FIND, '0);
      offer_request(MODE_RESERVE, 15'd512);
      offer_request(MODE_RESERVE, 15'd512);
      offer_request(MODE_FIND, '0);
      offer_request(MODE_RELEASE, 15'd512);
      offer_request(MODE_RELEASE, 15'd512);
      offer_request(MODE_RELEASE, 15'd0);
      offer_request(MODE_RESERVE, 15'd0);
      offer_request(MODE_RESERVE, 15'h7fff);
      offer_request(MODE_RELEASE, 15'h7fff);
      offer_request(MODE_IDLE, 15'h7fff);
      offer_request(MODE_IDLE, 15'd0);
      offer_request(MODE_FIND, 15'h7fff);

      // Scanning only the kernel words runs out of memory until a kernel page is freed.
      configure(10'd0, 11'd16);
      offer_request(MODE_FIND, '0);
      offer_request(MODE_RELEASE, 15'd31);
      offer_request(MODE_FIND, '0);
      offer_request(MODE_RESERVE, 15'd31);

      // Last word, word count beyond the bitmap, and windows that hold nothing.
      configure(10'd1023, 11'h7ff);
      offer_request(MODE_FIND, '0);
      configure(10'd1023, 11'd1023);
      offer_request(MODE_FIND, '0);
      configure(10'd0, 11'd0);
      offer_request(MODE_FIND, '0);
      configure(10'd0, 11'd1);
      offer_request(MODE_FIND, '0);

      // Random phases. Fill phases reserve pages of the window in order so that words
      // become full and finds must skip them or report out of memory.
      cursor = 0;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            first = 0;
            span = $urandom_range(17, 19);
         end else if (pick == 1) begin
            first = 1023;
            span = 1;
         end else begin
            first = $urandom_range(16, 1022);
            span = $urandom_range(1, 3);
            if (first + span > BITMAP_WORDS) span = BITMAP_WORDS - first;
         end
         limit = first + span;
         if (pick == 9) limit = $urandom_range(limit, 2047);
         configure(first[9:0], limit[10:0]);

         fill = (phase % 2 == 0);
         cursor = 0;
         tx_burst = ($urandom_range(0, 3) == 0);
         // One phase stalls the result side for a long stretch while items keep coming.
         if (phase == 2) begin
            rsp_hold = 150;
            tx_burst = 1'b1;
         end

         for (k = 0; k < PHASE_ITEMS; k++) begin
            roll = $urandom_range(0, 99);
            if (fill) begin
               page = PAGE_W'(first * 32 + cursor % (span * 32));
            end else begin
               page = PAGE_W'(first * 32 + $urandom_range(0, span * 32 - 1));
            end
            if (roll < 35) begin
               offer_request(MODE_FIND, PAGE_W'($urandom_range(0, 32767)));
            end else if (roll < (fill ? 80 : 55)) begin
               offer_request(MODE_RESERVE, page);
               if (fill) cursor++;
            end else if (roll < 90) begin
               offer_request(MODE_RELEASE,
                             PAGE_W'(first * 32 + $urandom_range(0, span * 32 - 1)));
            end else if (roll < 95) begin
               offer_request(MODE_IDLE, PAGE_W'($urandom_range(0, 32767)));
            end else begin
               offer_request($urandom_range(0, 1) ? MODE_RESERVE : MODE_RELEASE,
                             PAGE_W'($urandom_range(0, 32767)));
            end
            if (k == PHASE_ITEMS / 2) tx_burst = !tx_burst;
         end
      end

      // Drain, then give a stray result time to show up.
      settle();
      repeat (40) @(negedge clock);

      $display("Run offered %0d items under %0d scan windows, with bursts,", offered, settings);
      $display("a long result stall and %0d checked results (%0d finds hit, %0d out of memory).",
               checked, finds_hit, finds_missed);
      if (mismatches == 0 && awaiting == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
